FILE: rtl/core/swbcc_pkg.sv
`default_nettype none

package swbcc_pkg;

  localparam int LEVELS_DEFAULT = 16;
  localparam int WORLDS_DEFAULT = 4;
  localparam int SLOTS_DEFAULT  = 16;

  localparam int CoordW = 20;
  localparam int OutW   = 18;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic        obst;
    logic [11:0] h;
    logic [11:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  typedef struct packed {
    logic [2:0] dir;
    coord_t     mov_top;
    coord_t     mov_bot;
    coord_t     mov_left;
    coord_t     mov_right;
    coord_t     near_ref;
  } query_t;

  function automatic coord_t sext16(input logic [15:0] v);
    return coord_t'({{(CoordW-16){v[15]}}, v});
  endfunction

  function automatic coord_t zext12(input logic [11:0] v);
    return coord_t'({{(CoordW-12){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/swbcc_mem.sv
`default_nettype none

module swbcc_mem import swbcc_pkg::*; #(
  parameter int DEPTH = LEVELS_DEFAULT * WORLDS_DEFAULT * SLOTS_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire entry_t            wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output entry_t                 rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/swbcc_gap_unit.sv
`default_nettype none

module swbcc_gap_unit import swbcc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   init_i,
  input  wire coord_t init_val_i,
  input  wire query_t query_i,
  input  wire logic   ent_valid_i,
  input  wire entry_t ent_i,
  output coord_t      min_o,
  output logic        busy_o
);

  logic   edge_vld_q;
  logic   cand_vld_q;
  coord_t min_q;
  coord_t left_q, top_q, right_q, bot_q;
  coord_t cand_q, cand_d;
  coord_t op_a, op_b;
  logic   dir_move;
  logic   overlap;

  // Edges of the stored box are registered before the compare stage.
  always_ff @(posedge clk_i) begin
    left_q  <= sext16(ent_i.x);
    top_q   <= sext16(ent_i.y);
    right_q <= sext16(ent_i.x) + zext12(ent_i.w) - coord_t'(1);
    bot_q   <= sext16(ent_i.y) + zext12(ent_i.h) - coord_t'(1);
    cand_q  <= cand_d;
  end

  assign overlap = !((top_q > query_i.mov_bot) || (query_i.mov_top > bot_q) ||
                     (query_i.mov_left > right_q) || (query_i.mov_right < left_q));

  always_comb begin
    op_a     = '0;
    op_b     = '0;
    dir_move = 1'b1;
    unique case (query_i.dir)
      DIR_UP: begin
        op_a = bot_q;
        op_b = query_i.near_ref;
      end
      DIR_DOWN: begin
        op_a = top_q;
        op_b = query_i.near_ref;
      end
      DIR_LEFT: begin
        op_a = query_i.near_ref;
        op_b = right_q;
      end
      DIR_RIGHT: begin
        op_a = left_q;
        op_b = query_i.near_ref;
      end
      default: begin
        dir_move = 1'b0;
      end
    endcase
    cand_d = op_a - op_b;
  end

  // The running minimum never exceeds the step length, so no cap is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_vld_q <= 1'b0;
      cand_vld_q <= 1'b0;
      min_q      <= '0;
    end else begin
      edge_vld_q <= ent_valid_i && ent_i.obst;
      cand_vld_q <= edge_vld_q && overlap && dir_move;
      if (init_i) begin
        min_q <= init_val_i;
      end else if (cand_vld_q && (cand_q < min_q)) begin
        min_q <= cand_q;
      end
    end
  end

  assign min_o  = min_q;
  assign busy_o = edge_vld_q || cand_vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/swept_box_collision_clamp_core.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  op_i .. move_dir_i
// out      output     out_valid_o / out_ready_i allowed_distance_o
//
// A load item is written to the table when it is taken and gives no result.
// A query is answered once its SLOTS scene entries are read, the read and compare stages
// have drained and the result is registered; a query for a scene out of range skips the
// reads. No item is taken while a query is in progress; a waiting result only holds a
// query in its finish state. After reset the obstacle flags of all LEVELS * WORLDS * SLOTS
// entries (1024 by default) are cleared, during which no item is taken.
`default_nettype none

module swept_box_collision_clamp_core import swbcc_pkg::*; #(
  parameter int LEVELS = LEVELS_DEFAULT,
  parameter int WORLDS = WORLDS_DEFAULT,
  parameter int SLOTS  = SLOTS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [3:0]         scene_level_i,
  input  wire logic [1:0]         scene_world_i,
  input  wire logic [3:0]         slot_index_i,
  input  wire logic signed [15:0] box_x_i,
  input  wire logic signed [15:0] box_y_i,
  input  wire logic [11:0]        box_w_i,
  input  wire logic [11:0]        box_h_i,
  input  wire logic               is_obstacle_i,
  input  wire logic [11:0]        step_length_i,
  input  wire logic [2:0]         move_dir_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [OutW-1:0]  allowed_distance_o
);

  localparam int Depth = LEVELS * WORLDS * SLOTS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CurW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CurW-1:0]  LastSlot = CurW'(SLOTS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic             rd_valid_q;
  logic             out_valid_q, out_valid_d;
  logic signed [OutW-1:0] out_q, out_d;

  coord_t     a_top_q, a_bot_q, a_left_q, a_right_q, delta_q;
  logic [2:0] dir_q;
  query_t     qry_q, qry_d;
  coord_t     dx, dy;

  logic             accept;
  logic             scene_ok, slot_ok;
  logic [AddrW-1:0] scene_base;
  logic             mem_we, mem_re, gap_init, gap_busy;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  coord_t           gap_min;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign scene_ok = (32'(scene_level_i) < 32'(LEVELS)) && (scene_world_i != 2'd0) &&
                    (32'(scene_world_i) <= 32'(WORLDS));
  assign slot_ok  = 32'(slot_index_i) < 32'(SLOTS);
  assign scene_base = AddrW'((32'(scene_level_i) * 32'(WORLDS) + 32'(scene_world_i)
                              - 32'd1) * 32'(SLOTS));
  assign mem_raddr  = base_q + AddrW'(cursor_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    cursor_d    = cursor_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = scene_base + AddrW'(slot_index_i);
    mem_wdata   = '{obst: is_obstacle_i, h: box_h_i, w: box_w_i, y: box_y_i, x: box_x_i};
    gap_init    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            mem_we = scene_ok && slot_ok;
          end else begin
            gap_init = 1'b1;
            if (scene_ok) begin
              base_d   = scene_base;
              cursor_d = '0;
              state_d  = ST_WALK;
            end else begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_WALK: begin
        mem_re = 1'b1;
        if (cursor_q == LastSlot) begin
          cursor_d = '0;
          state_d  = ST_DRAIN;
        end else begin
          cursor_d = cursor_q + CurW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !gap_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = gap_min[OutW-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      rd_valid_q  <= mem_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    out_q  <= out_d;
    qry_q  <= qry_d;
    if (accept && (op_i == OP_QUERY)) begin
      a_top_q   <= sext16(box_y_i);
      a_bot_q   <= sext16(box_y_i) + zext12(box_h_i) - coord_t'(1);
      a_left_q  <= sext16(box_x_i);
      a_right_q <= sext16(box_x_i) + zext12(box_w_i) - coord_t'(1);
      delta_q   <= zext12(step_length_i);
      dir_q     <= move_dir_i;
    end
  end

  // The moved edges are ready before the first stored box reaches the compare stage.
  always_comb begin
    dx             = '0;
    dy             = '0;
    qry_d.near_ref = '0;
    unique case (dir_q)
      DIR_UP: begin
        dy             = -delta_q;
        qry_d.near_ref = a_top_q + coord_t'(1);
      end
      DIR_DOWN: begin
        dy             = delta_q;
        qry_d.near_ref = a_bot_q + coord_t'(1);
      end
      DIR_LEFT: begin
        dx             = -delta_q;
        qry_d.near_ref = a_left_q - coord_t'(1);
      end
      DIR_RIGHT: begin
        dx             = delta_q;
        qry_d.near_ref = a_right_q + coord_t'(1);
      end
      default: begin
        dx = '0;
      end
    endcase
    qry_d.dir       = dir_q;
    qry_d.mov_top   = a_top_q + dy;
    qry_d.mov_bot   = a_bot_q + dy;
    qry_d.mov_left  = a_left_q + dx;
    qry_d.mov_right = a_right_q + dx;
  end

  swbcc_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  swbcc_gap_unit u_gap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (gap_init),
    .init_val_i  (zext12(step_length_i)),
    .query_i     (qry_q),
    .ent_valid_i (rd_valid_q),
    .ent_i       (mem_rdata),
    .min_o       (gap_min),
    .busy_o      (gap_busy)
  );

  assign out_valid_o        = out_valid_q;
  assign allowed_distance_o = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_valid_q && !gap_busy))
    else $error("item taken while the compare pipeline still holds work");

  a_walk_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && (cursor_q != LastSlot)) |=> (state_q == ST_WALK))
    else $error("scene walk ended before the last slot");

  a_min_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DRAIN) || (state_q == ST_FINISH)) |-> (gap_min <= delta_q))
    else $error("running minimum exceeds the step length");

endmodule

`default_nettype wire

FILE: tb/sv/swept_box_collision_clamp_core_test.sv
`timescale 1ns / 100ps

module swept_box_collision_clamp_core_test;
  import swbcc_pkg::*;

  localparam int TableDepth = LEVELS_DEFAULT * WORLDS_DEFAULT * SLOTS_DEFAULT;
  localparam int CycleLimit = 500000;
  localparam logic [2:0] DIR_NONE = 3'd4;

  typedef struct packed {
    logic        op;
    logic [3:0]  level;
    logic [1:0]  world;
    logic [3:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic        obst;
    logic [11:0] step;
    logic [2:0]  dir;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [3:0] scene_level = '0;
  logic [1:0] scene_world = '0;
  logic [3:0] slot_index = '0;
  logic signed [15:0] box_x = '0;
  logic signed [15:0] box_y = '0;
  logic [11:0] box_w = '0;
  logic [11:0] box_h = '0;
  logic is_obstacle = 1'b0;
  logic [11:0] step_length = '0;
  logic [2:0] move_dir = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [OutW-1:0] allowed_distance;

  logic signed [15:0] tab_x [TableDepth];
  logic signed [15:0] tab_y [TableDepth];
  logic [11:0] tab_w [TableDepth];
  logic [11:0] tab_h [TableDepth];
  logic tab_obst [TableDepth];

  logic signed [OutW-1:0] distance_q [$];

  int error_count = 0;
  int results_checked = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int clamped_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit no_idle = 1'b0;
  int hold_request = 0;
  int rx_hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  swept_box_collision_clamp_core i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .op_i               (op),
    .scene_level_i      (scene_level),
    .scene_world_i      (scene_world),
    .slot_index_i       (slot_index),
    .box_x_i            (box_x),
    .box_y_i            (box_y),
    .box_w_i            (box_w),
    .box_h_i            (box_h),
    .is_obstacle_i      (is_obstacle),
    .step_length_i      (step_length),
    .move_dir_i         (move_dir),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .allowed_distance_o (allowed_distance)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      tab_x[i] = '0;
      tab_y[i] = '0;
      tab_w[i] = '0;
      tab_h[i] = '0;
      tab_obst[i] = 1'b0;
    end
  end

  function automatic bit scene_index(cmd_t c, output int base);
    base = 0;
    if (int'(c.level) >= LEVELS_DEFAULT || c.world == 2'd0 ||
        int'(c.world) > WORLDS_DEFAULT) begin
      return 1'b0;
    end
    base = (int'(c.level) * WORLDS_DEFAULT + int'(c.world) - 1) * SLOTS_DEFAULT;
    return 1'b1;
  endfunction

  function automatic void store_box(cmd_t c);
    int base;
    int idx;
    if (scene_index(c, base) && int'(c.slot) < SLOTS_DEFAULT) begin
      idx = base + int'(c.slot);
      tab_x[idx] = c.x;
      tab_y[idx] = c.y;
      tab_w[idx] = c.w;
      tab_h[idx] = c.h;
      tab_obst[idx] = c.obst;
    end
  endfunction

  function automatic logic signed [OutW-1:0] clamp_distance(cmd_t c);
    int base, idx, delta, best, cur, dx, dy;
    int top_a, bot_a, left_a, right_a, top_b, bot_b, left_b, right_b;
    bit ok;
    ok = scene_index(c, base);
    delta = int'(c.step);
    top_a = int'($signed(c.y));
    left_a = int'($signed(c.x));
    bot_a = top_a + int'(c.h) - 1;
    right_a = left_a + int'(c.w) - 1;
    dx = 0;
    dy = 0;
    case (c.dir)
      DIR_UP:    dy = -delta;
      DIR_DOWN:  dy = delta;
      DIR_LEFT:  dx = -delta;
      DIR_RIGHT: dx = delta;
      default:   dx = 0;
    endcase
    best = delta;
    for (int s = 0; ok && s < SLOTS_DEFAULT; s++) begin
      idx = base + s;
      if (tab_obst[idx]) begin
        left_b = int'(tab_x[idx]);
        top_b = int'(tab_y[idx]);
        right_b = left_b + int'(tab_w[idx]) - 1;
        bot_b = top_b + int'(tab_h[idx]) - 1;
        if (!(top_b > bot_a + dy || top_a + dy > bot_b ||
              left_a + dx > right_b || right_a + dx < left_b)) begin
          cur = best;
          if (c.dir == DIR_UP && top_a - delta <= bot_b) begin
            cur = bot_b - top_a - 1;
          end else if (c.dir == DIR_DOWN && bot_a + delta >= top_b) begin
            cur = top_b - bot_a - 1;
          end else if (c.dir == DIR_LEFT && left_a - delta <= right_b) begin
            cur = left_a - right_b - 1;
          end else if (c.dir == DIR_RIGHT && right_a + delta >= left_b) begin
            cur = left_b - right_a - 1;
          end
          if (cur > delta) begin
            cur = delta;
          end
          if (cur < best) begin
            best = cur;
          end
        end
      end
    end
    return best[OutW-1:0];
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = 1'($urandom_range(0, 1));
    c.level = 4'($urandom_range(0, 15));
    c.world = 2'($urandom_range(0, 3));
    c.slot = 4'($urandom_range(0, 15));
    c.x = 16'($urandom_range(0, 65535));
    c.y = 16'($urandom_range(0, 65535));
    c.w = 12'($urandom_range(0, 4095));
    c.h = 12'($urandom_range(0, 4095));
    c.obst = 1'($urandom_range(0, 1));
    c.step = 12'($urandom_range(0, 4095));
    c.dir = 3'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic cmd_t place_near(cmd_t c);
    int v;
    v = $urandom_range(0, 96) - 48;
    c.x = v[15:0];
    v = $urandom_range(0, 96) - 48;
    c.y = v[15:0];
    c.w = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
    c.h = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
    return c;
  endfunction

  function automatic cmd_t mk(logic opv, int lvl, int wld, int slot, int x, int y,
                              int w, int h, logic ob, int stp, int dr);
    cmd_t c;
    c.op = opv;
    c.level = lvl[3:0];
    c.world = wld[1:0];
    c.slot = slot[3:0];
    c.x = x[15:0];
    c.y = y[15:0];
    c.w = w[11:0];
    c.h = h[11:0];
    c.obst = ob;
    c.step = stp[11:0];
    c.dir = dr[2:0];
    return c;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  task automatic send_item(input cmd_t c);
    logic signed [OutW-1:0] predicted;
    @(negedge clk);
    in_valid = 1'b1;
    op = c.op;
    scene_level = c.level;
    scene_world = c.world;
    slot_index = c.slot;
    box_x = c.x;
    box_y = c.y;
    box_w = c.w;
    box_h = c.h;
    is_obstacle = c.obst;
    step_length = c.step;
    move_dir = c.dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (c.op == OP_QUERY) begin
      predicted = clamp_distance(c);
      if (predicted != $signed({6'd0, c.step})) begin
        clamped_count++;
      end
      distance_q.insert(distance_q.size(), predicted);
      queries_sent++;
    end else begin
      store_box(c);
      loads_sent++;
    end
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (no_idle) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 15) == 0) begin
      gap = $urandom_range(25, 60);
    end else if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end else begin
      gap = $urandom_range(1, 24);
    end
    if (gap > 0) begin
      idle_input(gap);
    end
    burst_left = $urandom_range(0, 15);
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (distance_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    cmd_t list [$];
    list = {list, mk(OP_LOAD, 0, 1, 0, 0, -40, 10, 10, 1'b1, 0, 0)};
    list = {list, mk(OP_LOAD, 0, 1, 15, 40, 0, 10, 10, 1'b1, 0, 0)};
    list = {list, mk(OP_LOAD, 0, 1, 1, 0, 20, 10, 10, 1'b0, 0, 0)};
    list = {list, mk(OP_LOAD, 0, 1, 2, -30, 0, 0, 0, 1'b1, 0, 0)};
    list = {list, mk(OP_LOAD, 0, 0, 3, 0, 20, 10, 10, 1'b1, 0, 0)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 50, DIR_UP)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 50, DIR_DOWN)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 4095, DIR_RIGHT)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 40, DIR_LEFT)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 0, 0, 1'b0, 40, DIR_LEFT)};
    for (int d = int'(DIR_NONE); d < 8; d++) begin
      list = {list, mk(OP_QUERY, 0, 1, 0, 0, -35, 10, 10, 1'b0, 100, d)};
    end
    list = {list, mk(OP_QUERY, 0, 1, 0, 2, -38, 4, 4, 1'b0, 5, DIR_UP)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 2, -38, 4, 4, 1'b0, 5, DIR_RIGHT)};
    list = {list, mk(OP_QUERY, 0, 0, 0, 0, 0, 10, 10, 1'b0, 50, DIR_DOWN)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 0, DIR_UP)};
    list = {list, mk(OP_LOAD, 15, 3, 7, -32768, 32767, 4095, 4095, 1'b1, 0, 0)};
    list = {list, mk(OP_LOAD, 15, 3, 8, 32767, -32768, 0, 4095, 1'b1, 0, 0)};
    list = {list, mk(OP_QUERY, 15, 3, 0, 32767, -32768, 4095, 4095, 1'b0, 4095, DIR_LEFT)};
    list = {list, mk(OP_QUERY, 15, 3, 0, -32768, 32767, 4095, 4095, 1'b0, 4095, DIR_UP)};
    list = {list, mk(OP_LOAD, 0, 1, 0, 0, -40, 10, 10, 1'b0, 0, 0)};
    list = {list, mk(OP_QUERY, 0, 1, 0, 0, 0, 10, 10, 1'b0, 50, DIR_UP)};
    foreach (list[i]) begin
      pace();
      send_item(list[i]);
    end
    wait_drained();
  endtask

  task automatic test_random_scenes();
    int lvl_pool [4];
    int wld_pool [4];
    int pick, lvl, wld;
    cmd_t c;
    for (int i = 0; i < 4; i++) begin
      lvl_pool[i] = $urandom_range(0, 15);
      wld_pool[i] = $urandom_range(1, 3);
    end
    while (items_sent < 1100) begin
      pick = $urandom_range(0, 3);
      lvl = lvl_pool[pick];
      wld = wld_pool[pick];
      repeat ($urandom_range(1, 8)) begin
        c = random_cmd();
        if ($urandom_range(0, 9) != 0) begin
          c = place_near(c);
        end
        c.op = OP_LOAD;
        c.level = lvl[3:0];
        c.world = wld[1:0];
        c.obst = ($urandom_range(0, 4) != 0);
        pace();
        send_item(c);
      end
      repeat ($urandom_range(2, 12)) begin
        c = random_cmd();
        if ($urandom_range(0, 9) != 0) begin
          c = place_near(c);
          c.level = lvl[3:0];
          c.world = wld[1:0];
        end
        c.op = ($urandom_range(0, 19) == 0) ? OP_LOAD : OP_QUERY;
        if ($urandom_range(0, 4) != 0) begin
          c.step = 12'($urandom_range(0, 64));
        end
        if ($urandom_range(0, 6) != 0) begin
          c.dir = 3'($urandom_range(0, 3));
        end
        pace();
        send_item(c);
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    cmd_t c;
    no_idle = 1'b1;
    hold_request = 300;
    repeat (24) begin
      c = place_near(random_cmd());
      c.op = OP_QUERY;
      c.level = 4'd0;
      c.world = 2'd1;
      c.step = 12'($urandom_range(0, 64));
      c.dir = 3'($urandom_range(0, 3));
      send_item(c);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_pause_drain();
    cmd_t c;
    repeat (3) begin
      repeat (6) begin
        c = place_near(random_cmd());
        c.level = 4'd0;
        c.world = 2'd1;
        c.step = 12'($urandom_range(0, 64));
        pace();
        send_item(c);
      end
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      rx_hold_left = hold_request;
      hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(5, 60);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        2: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = (cycle_count % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    logic signed [OutW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (distance_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with none expected", allowed_distance));
      end else begin
        want = distance_q.pop_front();
        results_checked++;
        if (allowed_distance !== want) begin
          report_error($sformatf("allowed_distance expected %0d, got %0d",
                                 want, allowed_distance));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, distance_q.size());
      $display("** swept_box_collision_clamp_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_scenes();
    test_backpressure();
    test_pause_drain();
    wait_drained();
    repeat (SLOTS_DEFAULT + 20) @(posedge clk);
    $display("Sent %0d loads and %0d queries; %0d results checked, %0d mismatches.",
             loads_sent, queries_sent, results_checked, error_count);
    $display("%0d queries were clamped by an obstacle.", clamped_count);
    if (error_count == 0) begin
      $display("** swept_box_collision_clamp_core: PASSED **");
    end else begin
      $display("** swept_box_collision_clamp_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/swbcc_pkg.sv
rtl/core/swbcc_mem.sv
rtl/core/swbcc_gap_unit.sv
rtl/core/swept_box_collision_clamp_core.sv
tb/sv/swept_box_collision_clamp_core_test.sv
